### design/lhb_pkg.sv
// Shared types and constants of the latency histogram binner.
`timescale 1ns / 1ps

package lhb_pkg;

  // Fixed field widths
  localparam int unsigned OP_W    = 3;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned BYTES_W = 32;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned ACC_W   = 64;
  localparam int unsigned CFG_W   = 6;

  // Threshold count after reset
  localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

  // Item operation codes
  typedef enum logic [OP_W-1:0] {
    OP_LOAD     = 3'd0,
    OP_SAMPLE   = 3'd1,
    OP_TRANSFER = 3'd2,
    OP_EVENT    = 3'd3,
    OP_READ     = 3'd4
  } op_e;

  // Running sums and counters, one slot each in the accumulator file
  typedef enum logic [2:0] {
    ACC_SAMPLES   = 3'd0,
    ACC_REAL_SUM  = 3'd1,
    ACC_EVENT_SUM = 3'd2,
    ACC_SUCCESS   = 3'd3,
    ACC_BYTES_IN  = 3'd4,
    ACC_BYTES_OUT = 3'd5,
    ACC_EVENTS    = 3'd6
  } acc_e;

  localparam int unsigned ACC_NUM = 7;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_ACC,
    ST_BIN_INC,
    ST_RD_ISSUE,
    ST_RD_TAKE,
    ST_DONE
  } state_e;

endpackage

### design/lhb_if.sv
// Valid/ready channel interfaces for items and results.
`timescale 1ns / 1ps

interface lhb_in_if #(
  parameter int unsigned TIME_BITS = 40
);
  logic                               valid;
  logic                               ready;
  logic [lhb_pkg::OP_W-1:0]           operation;
  logic [lhb_pkg::SLOT_W-1:0]         slot;
  logic [TIME_BITS-1:0]               time_value;
  logic [TIME_BITS-1:0]               event_time;
  logic [lhb_pkg::BYTES_W-1:0]        bytes_in;
  logic [lhb_pkg::BYTES_W-1:0]        bytes_out;

  modport source (output valid, operation, slot, time_value, event_time, bytes_in,
                  bytes_out, input ready);
  modport sink (input valid, operation, slot, time_value, event_time, bytes_in,
                bytes_out, output ready);
endinterface

interface lhb_out_if;
  logic                         valid;
  logic                         ready;
  logic [lhb_pkg::SLOT_W-1:0]   bucket;
  logic [lhb_pkg::COUNT_W-1:0]  bin_count;

  modport source (output valid, bucket, bin_count, input ready);
  modport sink (input valid, bucket, bin_count, output ready);
endinterface

### design/latency_histogram_binner.sv
// Top level: threshold bucketing, bin counters and running sums on one shared adder.
// Latency sample: the n thresholds in use are scanned, n = thresholds in use;
//   one threshold is compared per cycle on the shared add/compare unit.
// Transfer sizes update three running sums, an event one; read bin issues and then takes a read.
// The result sits in an output register; the next transaction may enter meanwhile.
// Reset: async, active low; then a clearing pass zeroes all MAX_THRESHOLDS + 1 entries of
//   the bin memory while no transaction is accepted.
`timescale 1ns / 1ps

module latency_histogram_binner #(
  parameter int unsigned MAX_THRESHOLDS = 32,
  parameter int unsigned TIME_BITS      = 40
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lhb_pkg::CFG_W-1:0]   cfg_wdata_i,
  lhb_in_if.sink                      in_i,
  lhb_out_if.source                   out_o
);

  localparam int unsigned IW = $clog2(MAX_THRESHOLDS);
  localparam int unsigned CW = $clog2(MAX_THRESHOLDS + 1);

  // Configuration register
  logic [lhb_pkg::CFG_W-1:0] thr_used_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_used_q <= lhb_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      thr_used_q <= cfg_wdata_i;
    end
  end

  // Clamped number of thresholds in use
  logic [CW-1:0] n_used;

  always_comb begin
    if (thr_used_q == '0) begin
      n_used = CW'(1);
    end else if (int'(thr_used_q) > int'(MAX_THRESHOLDS)) begin
      n_used = CW'(MAX_THRESHOLDS);
    end else begin
      n_used = CW'(thr_used_q);
    end
  end

  // Sequencer and item registers
  lhb_pkg::state_e               state_q, state_d;
  logic [CW-1:0]                 idx_q, idx_d;
  logic [CW-1:0]                 k_q, k_d;
  logic [1:0]                    step_q, step_d;
  logic [CW-1:0]                 clr_q, clr_d;
  logic [CW-1:0]                 last_q;
  logic [lhb_pkg::SLOT_W-1:0]    res_bucket_q, res_bucket_d;
  logic [lhb_pkg::COUNT_W-1:0]   res_cnt_q, res_cnt_d;

  lhb_pkg::op_e                  op_q;
  logic [lhb_pkg::SLOT_W-1:0]    slot_q;
  logic [TIME_BITS-1:0]          tval_q;
  logic [TIME_BITS-1:0]          etime_q;
  logic [lhb_pkg::BYTES_W-1:0]   bin_q;
  logic [lhb_pkg::BYTES_W-1:0]   bout_q;

  logic                          out_valid_q;
  logic [lhb_pkg::SLOT_W-1:0]    out_bucket_q;
  logic [lhb_pkg::COUNT_W-1:0]   out_cnt_q;

  logic in_fire;
  assign in_i.ready = (state_q == lhb_pkg::ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  // Memories
  logic [TIME_BITS-1:0]        thr_mem [MAX_THRESHOLDS];
  logic [TIME_BITS-1:0]        thr_rd_q;
  logic [IW-1:0]               thr_raddr;
  logic                        thr_we;

  logic [lhb_pkg::COUNT_W-1:0] bin_mem [MAX_THRESHOLDS + 1];
  logic [lhb_pkg::COUNT_W-1:0] bin_rd_q;
  logic [CW-1:0]               bin_raddr;
  logic                        bin_we;
  logic [CW-1:0]               bin_waddr;
  logic [lhb_pkg::COUNT_W-1:0] bin_wdata;

  // Accumulator file
  logic [lhb_pkg::ACC_W-1:0]   acc_q [lhb_pkg::ACC_NUM];
  lhb_pkg::acc_e               acc_sel;
  logic                        acc_we;

  // Shared add/compare unit: a + b, or a - b with carry out meaning a >= b
  logic [lhb_pkg::ACC_W-1:0]   alu_a, alu_b;
  logic                        alu_sub;
  logic [lhb_pkg::ACC_W:0]     alu_sum;

  assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b ^ {lhb_pkg::ACC_W{alu_sub}}}
                 + {{lhb_pkg::ACC_W{1'b0}}, alu_sub};

  logic acc_last;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    k_d          = k_q;
    step_d       = step_q;
    clr_d        = clr_q;
    res_bucket_d = res_bucket_q;
    res_cnt_d    = res_cnt_q;
    thr_we       = 1'b0;
    thr_raddr    = '0;
    bin_raddr    = k_q;
    bin_we       = 1'b0;
    bin_waddr    = k_q;
    bin_wdata    = '0;
    acc_we       = 1'b0;
    acc_sel      = lhb_pkg::ACC_SAMPLES;
    alu_a        = '0;
    alu_b        = '0;
    alu_sub      = 1'b0;
    acc_last     = 1'b0;

    unique case (state_q)
      // Zero the bin memory one entry a cycle
      lhb_pkg::ST_CLEAR: begin
        bin_we    = 1'b1;
        bin_waddr = clr_q;
        clr_d     = clr_q + CW'(1);
        if (clr_q == CW'(MAX_THRESHOLDS)) begin
          state_d = lhb_pkg::ST_IDLE;
        end
      end

      // Take a transaction and dispatch on its operation
      lhb_pkg::ST_IDLE: begin
        idx_d        = '0;
        k_d          = '0;
        step_d       = '0;
        res_bucket_d = '0;
        res_cnt_d    = '0;
        if (in_fire) begin
          unique case (in_i.operation)
            lhb_pkg::OP_LOAD: begin
              thr_we  = int'(in_i.slot) < int'(MAX_THRESHOLDS);
              state_d = lhb_pkg::ST_DONE;
            end
            lhb_pkg::OP_SAMPLE:   state_d = lhb_pkg::ST_SCAN;
            lhb_pkg::OP_TRANSFER: state_d = lhb_pkg::ST_ACC;
            lhb_pkg::OP_EVENT:    state_d = lhb_pkg::ST_ACC;
            lhb_pkg::OP_READ:     state_d = lhb_pkg::ST_RD_ISSUE;
            default:              state_d = lhb_pkg::ST_DONE;
          endcase
        end
      end

      // Count thresholds strictly above the sample, one per cycle
      lhb_pkg::ST_SCAN: begin
        alu_a     = lhb_pkg::ACC_W'(tval_q);
        alu_b     = lhb_pkg::ACC_W'(thr_rd_q);
        alu_sub   = 1'b1;
        thr_raddr = IW'(idx_q + CW'(1));
        idx_d     = idx_q + CW'(1);
        if (!alu_sum[lhb_pkg::ACC_W]) begin
          k_d = k_q + CW'(1);
        end
        if (idx_q == last_q) begin
          state_d = lhb_pkg::ST_ACC;
        end
      end

      // Update running sums, one per cycle
      lhb_pkg::ST_ACC: begin
        acc_we  = 1'b1;
        alu_b   = lhb_pkg::ACC_W'(1);
        priority case (op_q)
          lhb_pkg::OP_SAMPLE: begin
            acc_last = (step_q == 2'd2);
            unique case (step_q)
              2'd0: acc_sel = lhb_pkg::ACC_SAMPLES;
              2'd1: begin
                acc_sel = lhb_pkg::ACC_REAL_SUM;
                alu_b   = lhb_pkg::ACC_W'(tval_q);
              end
              default: begin
                acc_sel = lhb_pkg::ACC_EVENT_SUM;
                alu_b   = lhb_pkg::ACC_W'(etime_q);
              end
            endcase
          end
          lhb_pkg::OP_TRANSFER: begin
            acc_last = (step_q == 2'd2);
            unique case (step_q)
              2'd0: acc_sel = lhb_pkg::ACC_SUCCESS;
              2'd1: begin
                acc_sel = lhb_pkg::ACC_BYTES_IN;
                alu_b   = lhb_pkg::ACC_W'(bin_q);
              end
              default: begin
                acc_sel = lhb_pkg::ACC_BYTES_OUT;
                alu_b   = lhb_pkg::ACC_W'(bout_q);
              end
            endcase
          end
          default: begin
            acc_last = 1'b1;
            acc_sel  = lhb_pkg::ACC_EVENTS;
          end
        endcase
        alu_a  = acc_q[acc_sel];
        step_d = step_q + 2'd1;
        if (acc_last) begin
          state_d = (op_q == lhb_pkg::OP_SAMPLE) ? lhb_pkg::ST_BIN_INC : lhb_pkg::ST_DONE;
        end
      end

      // Increment the chosen bin; its old count was read during the sums
      lhb_pkg::ST_BIN_INC: begin
        alu_a        = lhb_pkg::ACC_W'(bin_rd_q);
        alu_b        = lhb_pkg::ACC_W'(1);
        bin_we       = 1'b1;
        bin_wdata    = alu_sum[lhb_pkg::COUNT_W-1:0];
        res_bucket_d = lhb_pkg::SLOT_W'(k_q);
        res_cnt_d    = alu_sum[lhb_pkg::COUNT_W-1:0];
        state_d      = lhb_pkg::ST_DONE;
      end

      // Read one bin
      lhb_pkg::ST_RD_ISSUE: begin
        bin_raddr = CW'(slot_q);
        state_d   = lhb_pkg::ST_RD_TAKE;
      end

      lhb_pkg::ST_RD_TAKE: begin
        res_bucket_d = slot_q;
        res_cnt_d    = (int'(slot_q) <= int'(MAX_THRESHOLDS)) ? bin_rd_q : '0;
        state_d      = lhb_pkg::ST_DONE;
      end

      // Hand the result to the output register once it is free
      lhb_pkg::ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = lhb_pkg::ST_IDLE;
        end
      end

      default: state_d = lhb_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lhb_pkg::ST_CLEAR;
      idx_q   <= '0;
      k_q     <= '0;
      step_q  <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      k_q     <= k_d;
      step_q  <= step_d;
      clr_q   <= clr_d;
    end
  end

  // Item and result payload
  always_ff @(posedge clk_i) begin
    res_bucket_q <= res_bucket_d;
    res_cnt_q    <= res_cnt_d;
    if (in_fire) begin
      op_q    <= lhb_pkg::op_e'(in_i.operation);
      slot_q  <= in_i.slot;
      tval_q  <= in_i.time_value;
      etime_q <= in_i.event_time;
      bin_q   <= in_i.bytes_in;
      bout_q  <= in_i.bytes_out;
      last_q  <= n_used - CW'(1);
    end
  end

  // Threshold memory: written on a load, read one entry ahead of the scan
  always_ff @(posedge clk_i) begin
    if (thr_we) begin
      thr_mem[IW'(in_i.slot)] <= in_i.time_value;
    end
    thr_rd_q <= thr_mem[thr_raddr];
  end

  // Bin count memory
  always_ff @(posedge clk_i) begin
    if (bin_we) begin
      bin_mem[bin_waddr] <= bin_wdata;
    end
    bin_rd_q <= bin_mem[bin_raddr];
  end

  // Accumulators wrap at 64 bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(lhb_pkg::ACC_NUM); i++) begin
        acc_q[i] <= '0;
      end
    end else if (acc_we) begin
      acc_q[acc_sel] <= alu_sum[lhb_pkg::ACC_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == lhb_pkg::ST_DONE && (!out_valid_q || out_o.ready)) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == lhb_pkg::ST_DONE && (!out_valid_q || out_o.ready)) begin
      out_bucket_q <= res_bucket_q;
      out_cnt_q    <= res_cnt_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.bucket    = out_bucket_q;
  assign out_o.bin_count = out_cnt_q;

  // Checks
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lhb_pkg::ST_SCAN) |-> (k_q <= idx_q))
    else $error("bucket count ran ahead of thresholds scanned");

  a_rise_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == lhb_pkg::ST_DONE))
    else $error("result raised outside the done state");

  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lhb_pkg::ST_CLEAR) |=> !(state_q == lhb_pkg::ST_SCAN ||
                                         state_q == lhb_pkg::ST_ACC))
    else $error("transaction started during bin clearing");

endmodule
